FILE: rtl/core/gcm_pkg.sv
// gcm_pkg: shared types and constants for the gradient color map block
// no dependencies; used by every file under rtl/core
`timescale 1ns / 1ps
`default_nettype none
package gcm_pkg;

   // default parameter values
   localparam int MAX_STOPS_DEF     = 5;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int QUEUE_DEPTH       = 4;

   // field widths
   localparam int VAL_W     = 32;
   localparam int STOP_W    = 41;
   localparam int RGB_W     = 24;
   localparam int CH_W      = 8;
   localparam int COUNT_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int POS_LSB   = 24;

   localparam logic [RGB_W-1:0] WHITE_RGB = 24'hFFFFFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_VALUE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VALUE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_COUNT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_BASE  = 3'd3;

   // classification of a sample by the front end
   typedef enum logic [1:0] {
      KIND_WHITE,
      KIND_FIRST,
      KIND_LAST,
      KIND_FRAC
   } kind_type;

   // handshake-free status between pipeline parts
   typedef struct packed {
      logic     valid;
      kind_type kind;
   } item_ctl_type;

endpackage
`default_nettype wire

FILE: rtl/core/gcm_front.sv
// gcm_front: normalizes a sample against min/max, classifies it and
// computes the fraction with a one-bit-per-stage divider; uses gcm_pkg
`timescale 1ns / 1ps
`default_nettype none
module gcm_front #(
   parameter int FRACTION_BITS = gcm_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [gcm_pkg::VAL_W-1:0]     sample_value,
   input  wire logic [gcm_pkg::VAL_W-1:0]     min_value,
   input  wire logic [gcm_pkg::VAL_W-1:0]     max_value,
   input  wire logic                          count_zero,
   output gcm_pkg::item_ctl_type              out_ctl,
   output logic [FRACTION_BITS-1:0]           out_frac
);

   localparam int F  = FRACTION_BITS;
   localparam int DW = gcm_pkg::VAL_W + 1;

   logic signed [DW-1:0] n_w, d_w;
   logic [DW-1:0]        an_w, ad_w;
   gcm_pkg::kind_type    kind_w;

   logic              vld_ff  [0:F];
   gcm_pkg::kind_type kind_ff [0:F];
   logic [DW-1:0]     rem_ff  [0:F];
   logic [DW-1:0]     ad_ff   [0:F];
   logic [F-1:0]      q_ff    [0:F];

   logic [DW:0]   sh_w   [0:F-1];
   logic          ge_w   [0:F-1];
   logic [DW-1:0] rem_in [0:F-1];

   // difference against min and span, with classification
   always_comb begin
      n_w  = $signed({sample_value[gcm_pkg::VAL_W-1], sample_value})
           - $signed({min_value[gcm_pkg::VAL_W-1], min_value});
      d_w  = $signed({max_value[gcm_pkg::VAL_W-1], max_value})
           - $signed({min_value[gcm_pkg::VAL_W-1], min_value});
      an_w = n_w[DW-1] ? DW'(-n_w) : DW'(n_w);
      ad_w = d_w[DW-1] ? DW'(-d_w) : DW'(d_w);
      if (count_zero) begin
         kind_w = gcm_pkg::KIND_WHITE;
      end else if (d_w == '0) begin
         if (n_w > 0) kind_w = gcm_pkg::KIND_LAST;
         else if (n_w < 0) kind_w = gcm_pkg::KIND_FIRST;
         else kind_w = gcm_pkg::KIND_WHITE;
      end else if (n_w == '0 || (n_w[DW-1] != d_w[DW-1])) begin
         kind_w = gcm_pkg::KIND_FIRST;
      end else if (an_w >= ad_w) begin
         kind_w = gcm_pkg::KIND_LAST;
      end else begin
         kind_w = gcm_pkg::KIND_FRAC;
      end
   end

   // restoring divider step per stage
   always_comb begin
      for (int i = 0; i < F; i++) begin
         sh_w[i]   = {rem_ff[i], 1'b0};
         ge_w[i]   = sh_w[i] >= {1'b0, ad_ff[i]};
         rem_in[i] = ge_w[i] ? DW'(sh_w[i] - {1'b0, ad_ff[i]}) : sh_w[i][DW-1:0];
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= F; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= F; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // payload chain
   always_ff @(posedge clock) begin
      kind_ff[0] <= kind_w;
      rem_ff[0]  <= an_w;
      ad_ff[0]   <= ad_w;
      q_ff[0]    <= '0;
      for (int i = 1; i <= F; i++) begin
         kind_ff[i] <= kind_ff[i-1];
         rem_ff[i]  <= rem_in[i-1];
         ad_ff[i]   <= ad_ff[i-1];
         q_ff[i]    <= {q_ff[i-1][F-2:0], ge_w[i-1]};
      end
   end

   assign out_ctl.valid = vld_ff[F];
   assign out_ctl.kind  = kind_ff[F];
   assign out_frac      = q_ff[F];

endmodule
`default_nettype wire

FILE: rtl/core/gcm_queue.sv
// gcm_queue: small fifo between the front end and the back end
// uses gcm_pkg for its default depth
`timescale 1ns / 1ps
`default_nettype none
module gcm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = gcm_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty,
   output logic                  full
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [0:DEPTH-1];
   logic [AW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign empty   = cnt_ff == '0;
   assign full    = cnt_ff == CW'(DEPTH);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_data = slot_ff[rptr_ff];

   // pointer and count update
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (do_push) wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wptr_ff + 1'b1);
      if (do_pop)  rptr_in = (rptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(rptr_ff + 1'b1);
      cnt_in = CW'(cnt_ff + CW'(do_push) - CW'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

FILE: rtl/core/gcm_back.sv
// gcm_back: segment search, channel products and pipelined channel division
// uses gcm_pkg
`timescale 1ns / 1ps
`default_nettype none
module gcm_back #(
   parameter int MAX_STOPS     = gcm_pkg::MAX_STOPS_DEF,
   parameter int FRACTION_BITS = gcm_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire gcm_pkg::item_ctl_type          in_ctl,
   input  wire logic [FRACTION_BITS-1:0]       in_frac,
   input  wire logic [gcm_pkg::STOP_W-1:0]     stops [0:MAX_STOPS-1],
   input  wire logic [gcm_pkg::COUNT_W-1:0]    stop_count,
   output logic                                out_valid,
   output logic [gcm_pkg::RGB_W-1:0]           out_rgb,
   output logic                                out_default
);

   localparam int PW = FRACTION_BITS + 1;
   localparam int SW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
   localparam int CH = gcm_pkg::CH_W;
   localparam int NW = CH + PW;
   localparam int DS = CH;

   // segment search
   logic [PW-1:0]              pos_w [0:MAX_STOPS-1];
   logic [PW-1:0]              frac_w;
   logic [SW-1:0]              sel_w, last_w;
   logic                       hit_w;
   logic [gcm_pkg::RGB_W-1:0]  c0_w, c1_w, dir_rgb_w;
   logic [PW-1:0]              span_w;
   logic                       direct_w, dflt_w;

   always_comb begin
      frac_w = PW'(in_frac);
      for (int i = 0; i < MAX_STOPS; i++) begin
         pos_w[i] = PW'(stops[i] >> gcm_pkg::POS_LSB);
      end
      sel_w = '0;
      hit_w = 1'b0;
      for (int i = MAX_STOPS - 2; i >= 0; i--) begin
         if ((i + 1) < int'(stop_count) && frac_w >= pos_w[i] && frac_w <= pos_w[i+1]) begin
            sel_w = SW'(i);
            hit_w = 1'b1;
         end
      end
      last_w = SW'(stop_count - 1'b1);
      c0_w   = stops[sel_w][gcm_pkg::RGB_W-1:0];
      c1_w   = stops[SW'(sel_w + 1'b1)][gcm_pkg::RGB_W-1:0];
      span_w = pos_w[SW'(sel_w + 1'b1)] - pos_w[sel_w];
      direct_w  = 1'b1;
      dflt_w    = 1'b0;
      dir_rgb_w = gcm_pkg::WHITE_RGB;
      case (in_ctl.kind)
         gcm_pkg::KIND_WHITE: begin
            dflt_w = 1'b1;
         end
         gcm_pkg::KIND_FIRST: begin
            dir_rgb_w = stops[0][gcm_pkg::RGB_W-1:0];
         end
         gcm_pkg::KIND_LAST: begin
            dir_rgb_w = stops[last_w][gcm_pkg::RGB_W-1:0];
         end
         gcm_pkg::KIND_FRAC: begin
            if (!hit_w) begin
               dflt_w = 1'b1;
            end else if (span_w == '0) begin
               dir_rgb_w = c0_w;
            end else begin
               direct_w = 1'b0;
            end
         end
         default: begin
            dflt_w = 1'b1;
         end
      endcase
   end

   // search stage registers
   logic                      s1_vld_ff;
   logic                      s1_direct_ff, s1_dflt_ff;
   logic [gcm_pkg::RGB_W-1:0] s1_rgb_ff, s1_c0_ff, s1_c1_ff;
   logic [PW-1:0]             s1_w0_ff, s1_w1_ff, s1_span_ff;

   always_ff @(posedge clock) begin
      s1_direct_ff <= direct_w;
      s1_dflt_ff   <= dflt_w;
      s1_rgb_ff    <= dir_rgb_w;
      s1_c0_ff     <= c0_w;
      s1_c1_ff     <= c1_w;
      s1_w0_ff     <= pos_w[SW'(sel_w + 1'b1)] - frac_w;
      s1_w1_ff     <= frac_w - pos_w[sel_w];
      s1_span_ff   <= (span_w == '0) ? PW'(1) : span_w;
   end

   // weighted sums per channel
   logic [NW-1:0] num_w [0:2];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num_w[c] = NW'(NW'(s1_c0_ff[c*CH +: CH]) * NW'(s1_w0_ff))
                  + NW'(NW'(s1_c1_ff[c*CH +: CH]) * NW'(s1_w1_ff));
      end
   end

   // division pipeline: stage 0 holds the sums, one quotient bit per stage
   logic                      dv_vld_ff    [0:DS];
   logic                      dv_direct_ff [0:DS];
   logic                      dv_dflt_ff   [0:DS];
   logic [gcm_pkg::RGB_W-1:0] dv_rgb_ff    [0:DS];
   logic [PW-1:0]             dv_span_ff   [0:DS];
   logic [NW-1:0]             dv_rem_ff    [0:DS][0:2];
   logic [CH-1:0]             dv_q_ff      [0:DS][0:2];

   logic [NW-1:0] dvs_w  [0:DS-1];
   logic          ge_w   [0:DS-1][0:2];
   logic [NW-1:0] rem_in [0:DS-1][0:2];

   always_comb begin
      for (int j = 0; j < DS; j++) begin
         dvs_w[j] = NW'(dv_span_ff[j]) << (DS - 1 - j);
         for (int c = 0; c < 3; c++) begin
            ge_w[j][c]   = dv_rem_ff[j][c] >= dvs_w[j];
            rem_in[j][c] = ge_w[j][c] ? NW'(dv_rem_ff[j][c] - dvs_w[j]) : dv_rem_ff[j][c];
         end
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         for (int j = 0; j <= DS; j++) dv_vld_ff[j] <= 1'b0;
         out_valid <= 1'b0;
      end else begin
         s1_vld_ff    <= in_ctl.valid;
         dv_vld_ff[0] <= s1_vld_ff;
         for (int j = 1; j <= DS; j++) dv_vld_ff[j] <= dv_vld_ff[j-1];
         out_valid <= dv_vld_ff[DS];
      end
   end

   // payload chain
   always_ff @(posedge clock) begin
      dv_direct_ff[0] <= s1_direct_ff;
      dv_dflt_ff[0]   <= s1_dflt_ff;
      dv_rgb_ff[0]    <= s1_rgb_ff;
      dv_span_ff[0]   <= s1_span_ff;
      for (int c = 0; c < 3; c++) begin
         dv_rem_ff[0][c] <= num_w[c];
         dv_q_ff[0][c]   <= '0;
      end
      for (int j = 1; j <= DS; j++) begin
         dv_direct_ff[j] <= dv_direct_ff[j-1];
         dv_dflt_ff[j]   <= dv_dflt_ff[j-1];
         dv_rgb_ff[j]    <= dv_rgb_ff[j-1];
         dv_span_ff[j]   <= dv_span_ff[j-1];
         for (int c = 0; c < 3; c++) begin
            dv_rem_ff[j][c] <= rem_in[j-1][c];
            dv_q_ff[j][c]   <= {dv_q_ff[j-1][c][CH-2:0], ge_w[j-1][c]};
         end
      end
      out_default <= dv_dflt_ff[DS];
      out_rgb     <= dv_direct_ff[DS] ? dv_rgb_ff[DS]
                   : {dv_q_ff[DS][2], dv_q_ff[DS][1], dv_q_ff[DS][0]};
   end

endmodule
`default_nettype wire

FILE: rtl/core/gradient_color_map.sv
// gradient_color_map: piecewise linear color gradient lookup, top level
// one transaction per cycle while busy is low
// the front end divider (one bit per stage) and the back end channel divider
// (eight stages) are fully pipelined; busy rises only if the queue fills
// reset is synchronous and active high; registers return to min 0, max 1.0,
// no stops; the receiver cannot stall, rsp_valid is a one-cycle strobe
// depends on gcm_pkg, gcm_front, gcm_queue, gcm_back
`timescale 1ns / 1ps
`default_nettype none
module gradient_color_map #(
   parameter int MAX_STOPS     = gcm_pkg::MAX_STOPS_DEF,
   parameter int FRACTION_BITS = gcm_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [gcm_pkg::VAL_W-1:0]        req_sample_value,
   output logic                                  rsp_valid,
   output logic [gcm_pkg::RGB_W-1:0]             rsp_rgb_color,
   output logic                                  rsp_used_default,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [gcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [gcm_pkg::STOP_W-1:0]       csr_data
);

   localparam int QW = 2 + FRACTION_BITS;

   logic [gcm_pkg::VAL_W-1:0]   min_ff, max_ff;
   logic [gcm_pkg::COUNT_W-1:0] count_ff, count_eff;
   logic [gcm_pkg::STOP_W-1:0]  stop_ff [0:MAX_STOPS-1];

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= '0;
         max_ff   <= gcm_pkg::VAL_W'(65536);
         count_ff <= '0;
         for (int i = 0; i < MAX_STOPS; i++) stop_ff[i] <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gcm_pkg::REG_MIN_VALUE:  min_ff   <= csr_data[gcm_pkg::VAL_W-1:0];
            gcm_pkg::REG_MAX_VALUE:  max_ff   <= csr_data[gcm_pkg::VAL_W-1:0];
            gcm_pkg::REG_STOP_COUNT: count_ff <= csr_data[gcm_pkg::COUNT_W-1:0];
            default: begin
               for (int i = 0; i < MAX_STOPS; i++) begin
                  if (int'(csr_index) == int'(gcm_pkg::REG_STOP_BASE) + i) stop_ff[i] <= csr_data;
               end
            end
         endcase
      end
   end

   // stop count clamped to what is stored
   assign count_eff = (int'(count_ff) > MAX_STOPS) ? gcm_pkg::COUNT_W'(MAX_STOPS) : count_ff;

   // front end
   gcm_pkg::item_ctl_type       fr_ctl;
   logic [FRACTION_BITS-1:0]    fr_frac;
   logic                        q_empty, q_full;
   logic [QW-1:0]               q_data;
   gcm_pkg::item_ctl_type       bk_ctl;

   assign busy = q_full;

   gcm_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start && !busy),
      .sample_value (req_sample_value),
      .min_value    (min_ff),
      .max_value    (max_ff),
      .count_zero   (count_eff == '0),
      .out_ctl      (fr_ctl),
      .out_frac     (fr_frac)
   );

   // queue between the two halves; the back end drains one entry per cycle
   gcm_queue #(.WIDTH(QW), .DEPTH(gcm_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_ctl.valid),
      .push_data ({fr_ctl.kind, fr_frac}),
      .pop       (1'b1),
      .pop_data  (q_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign bk_ctl.valid = !q_empty;
   assign bk_ctl.kind  = gcm_pkg::kind_type'(q_data[QW-1 -: 2]);

   // back end
   gcm_back #(.MAX_STOPS(MAX_STOPS), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (bk_ctl),
      .in_frac     (q_data[FRACTION_BITS-1:0]),
      .stops       (stop_ff),
      .stop_count  (count_eff),
      .out_valid   (rsp_valid),
      .out_rgb     (rsp_rgb_color),
      .out_default (rsp_used_default)
   );

endmodule
`default_nettype wire
